>>> rtl/amdfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package amdfs_pkg;

    localparam int CMD_W     = 3;
    localparam int LABEL_W   = 8;
    localparam int DATA_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int LIMIT_W   = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEGREE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WEIGHT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DFS    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NULL_EDGE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_LIMIT = 1'b1;

    // requests into the vertex table
    typedef struct packed {
        logic wr;
        logic rd;
        logic lk_start;
    } vt_req_t;

    // lookup completion from the vertex table
    typedef struct packed {
        logic lk_done;
        logic lk_hit;
    } vt_rsp_t;

endpackage

`default_nettype wire

>>> rtl/adjacency_matrix_dfs_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake          Beat
// command   start / busy       command, label_a, label_b, weight
// result    done (strobe)      status, value, visit_label, found, last
// config    cfg_we             cfg_index, cfg_data
//
// After reset the engine sweeps the adjacency memory, one entry a cycle, over
// all MAX_VERTICES * MAX_VERTICES entries; busy stays high during that sweep.
// Insert and unused codes answer without a lookup; set edge and edge weight
// are bound by the label lookup scans for both labels.
// Degree does one label lookup and then a row scan.
// A search pops up to MAX_VERTICES + 1 vertices; each pop costs a stack read,
// a label read, a label lookup and a row scan over the adjacency memory port.
// The result strobe cannot be stalled; each beat is valid for one cycle.

module adjacency_matrix_dfs_engine_top #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_WIDTH = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire [amdfs_pkg::CMD_W-1:0]          command,
    input  wire [amdfs_pkg::LABEL_W-1:0]        label_a,
    input  wire [amdfs_pkg::LABEL_W-1:0]        label_b,
    input  wire signed [amdfs_pkg::DATA_W-1:0]  weight,
    input  wire                                 cfg_we,
    input  wire [amdfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [amdfs_pkg::DATA_W-1:0]         cfg_data,
    output logic                                done,
    output logic [amdfs_pkg::STATUS_W-1:0]      status,
    output logic signed [amdfs_pkg::DATA_W-1:0] value,
    output logic [amdfs_pkg::LABEL_W-1:0]       visit_label,
    output logic                                found,
    output logic                                last
);
    import amdfs_pkg::*;

    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int SD  = MAX_VERTICES + 1;
    localparam int SAW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);
    localparam int NE  = MAX_VERTICES * MAX_VERTICES;
    localparam int AW  = $clog2(NE);
    localparam int WW  = WEIGHT_WIDTH;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_LKA    = 4'd2;
    localparam logic [3:0] S_LKB    = 4'd3;
    localparam logic [3:0] S_ADJRD  = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_POP    = 4'd6;
    localparam logic [3:0] S_TOP    = 4'd7;
    localparam logic [3:0] S_LAB    = 4'd8;
    localparam logic [3:0] S_LKROW  = 4'd9;

    // control state
    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [SPW-1:0]      sp_reg, sp_next;
    logic [SPW-1:0]      n_reg, n_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                pend_reg, pend_next;
    logic                done_reg, done_next;
    logic signed [DATA_W-1:0] null_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    // command context (payload)
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [LABEL_W-1:0]  la_reg, la_next;
    logic [LABEL_W-1:0]  lb_reg, lb_next;
    logic signed [DATA_W-1:0] w_reg, w_next;
    logic [IW-1:0]       ia_reg, ia_next;
    logic [IW-1:0]       row_reg, row_next;
    logic [IW-1:0]       top_reg, top_next;
    logic [LABEL_W-1:0]  lab_reg, lab_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [IW-1:0]       pcol_reg, pcol_next;
    logic [CW-1:0]       deg_reg, deg_next;

    // result beat
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [LABEL_W-1:0]  visit_reg, visit_next;
    logic                found_reg, found_next;
    logic                last_reg, last_next;

    // adjacency memory, single port, registered read
    logic signed [WW-1:0] adj_mem [NE];
    logic signed [WW-1:0] adj_q;
    logic                 adj_we;
    logic [IW-1:0]        adj_row, adj_col;
    logic [AW-1:0]        adj_addr;
    logic signed [WW-1:0] adj_wdata;
    logic signed [WW-1:0] null_w;
    logic signed [31:0]   adj_wide;

    // search stack memory
    logic [IW-1:0]        stk_mem [SD];
    logic [IW-1:0]        stk_q;
    logic                 stk_we;
    logic [SAW-1:0]       stk_waddr;
    logic [IW-1:0]        stk_wdata;
    logic [SPW-1:0]       sp_dec;
    logic [SAW-1:0]       stk_raddr;

    // vertex table
    vt_req_t              vt_req;
    vt_rsp_t              vt_rsp;
    logic [IW-1:0]        vt_idx;
    logic [LABEL_W-1:0]   vt_label;
    logic [IW-1:0]        vt_lk_idx;
    logic [LABEL_W-1:0]   vt_q;

    logic                 accept;
    logic                 table_full;
    logic                 scan_issue;
    logic                 scan_hit;

    amdfs_vtab #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_vtab (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (vt_req),
        .idx     (vt_idx),
        .label   (vt_label),
        .count   (count_reg),
        .rsp     (vt_rsp),
        .lk_idx  (vt_lk_idx),
        .rd_data (vt_q)
    );

    assign accept     = start && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign null_w     = WW'(null_reg);
    assign adj_wide   = 32'(adj_q);
    assign table_full = (32'(count_reg) >= 32'(limit_reg)) ||
                        (32'(count_reg) >= 32'(MAX_VERTICES));
    assign scan_issue = (col_reg < count_reg);
    assign scan_hit   = (adj_q != null_w);
    assign sp_dec     = sp_reg - SPW'(1);
    assign stk_raddr  = sp_dec[SAW-1:0];
    assign adj_addr   = (state_reg == S_CLEAR) ? clr_reg :
                        AW'(adj_row) * AW'(MAX_VERTICES) + AW'(adj_col);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        sp_next      = sp_reg;
        n_next       = n_reg;
        visited_next = visited_reg;
        clr_next     = clr_reg;
        pend_next    = 1'b0;
        done_next    = 1'b0;
        cmd_next     = cmd_reg;
        la_next      = la_reg;
        lb_next      = lb_reg;
        w_next       = w_reg;
        ia_next      = ia_reg;
        row_next     = row_reg;
        top_next     = top_reg;
        lab_next     = lab_reg;
        col_next     = col_reg;
        pcol_next    = pcol_reg;
        deg_next     = deg_reg;
        status_next  = status_reg;
        value_next   = value_reg;
        visit_next   = visit_reg;
        found_next   = found_reg;
        last_next    = last_reg;

        adj_we    = 1'b0;
        adj_row   = row_reg;
        adj_col   = col_reg[IW-1:0];
        adj_wdata = WW'(w_reg);
        stk_we    = 1'b0;
        stk_waddr = sp_reg[SAW-1:0];
        stk_wdata = pcol_reg;
        vt_req    = '0;
        vt_idx    = count_reg[IW-1:0];
        vt_label  = label_a;

        case (state_reg)
            S_CLEAR:
            begin
                // sweep every entry to the reset null value
                adj_we    = 1'b1;
                adj_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(NE - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = command;
                    la_next  = label_a;
                    lb_next  = label_b;
                    w_next   = weight;
                    case (command)
                        CMD_INSERT:
                        begin
                            done_next   = 1'b1;
                            value_next  = '0;
                            visit_next  = '0;
                            found_next  = 1'b0;
                            last_next   = 1'b1;
                            if (table_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                vt_req.wr   = 1'b1;
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        CMD_SET, CMD_DEGREE, CMD_WEIGHT:
                        begin
                            vt_req.lk_start = 1'b1;
                            state_next      = S_LKA;
                        end
                        CMD_DFS:
                        begin
                            visited_next = '0;
                            sp_next      = '0;
                            if (label_a == label_b)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_OK;
                                value_next  = '0;
                                visit_next  = label_a;
                                found_next  = 1'b1;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                vt_req.lk_start = 1'b1;
                                state_next      = S_LKA;
                            end
                        end
                        default:
                        begin
                            // unused codes: plain ok beat
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            value_next  = '0;
                            visit_next  = '0;
                            found_next  = 1'b0;
                            last_next   = 1'b1;
                        end
                    endcase
                end
            end

            S_LKA:
            begin
                if (vt_rsp.lk_done)
                begin
                    ia_next = vt_lk_idx;
                    if (!vt_rsp.lk_hit)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_MISS;
                        value_next  = '0;
                        visit_next  = (cmd_reg == CMD_DFS) ? la_reg : '0;
                        found_next  = 1'b0;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (cmd_reg == CMD_DEGREE)
                    begin
                        row_next   = vt_lk_idx;
                        col_next   = '0;
                        deg_next   = '0;
                        state_next = S_SCAN;
                    end
                    else if (cmd_reg == CMD_DFS)
                    begin
                        // push the origin, unmarked
                        stk_we     = 1'b1;
                        stk_waddr  = '0;
                        stk_wdata  = vt_lk_idx;
                        sp_next    = SPW'(1);
                        n_next     = '0;
                        state_next = S_POP;
                    end
                    else
                    begin
                        vt_req.lk_start = 1'b1;
                        vt_label        = lb_reg;
                        state_next      = S_LKB;
                    end
                end
            end

            S_LKB:
            begin
                adj_row = ia_reg;
                adj_col = vt_lk_idx;
                if (vt_rsp.lk_done)
                begin
                    if (!vt_rsp.lk_hit)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_MISS;
                        value_next  = '0;
                        visit_next  = '0;
                        found_next  = 1'b0;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (cmd_reg == CMD_SET)
                    begin
                        adj_we      = 1'b1;
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        value_next  = '0;
                        visit_next  = '0;
                        found_next  = 1'b0;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ADJRD;
                    end
                end
            end

            S_ADJRD:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                value_next  = adj_wide[DATA_W-1:0];
                visit_next  = '0;
                found_next  = 1'b0;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end

            S_POP:
            begin
                // stack read issued at sp - 1
                sp_next    = sp_dec;
                state_next = S_TOP;
            end

            S_TOP:
            begin
                top_next   = stk_q;
                vt_req.rd  = 1'b1;
                vt_idx     = stk_q;
                state_next = S_LAB;
            end

            S_LAB:
            begin
                lab_next = vt_q;
                if (vt_q == lb_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    value_next  = '0;
                    visit_next  = vt_q;
                    found_next  = 1'b1;
                    last_next   = 1'b1;
                    sp_next     = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    vt_req.lk_start = 1'b1;
                    vt_label        = vt_q;
                    state_next      = S_LKROW;
                end
            end

            S_LKROW:
            begin
                if (vt_rsp.lk_done)
                begin
                    row_next   = vt_rsp.lk_hit ? vt_lk_idx : top_reg;
                    col_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue one column read a cycle, judge it the cycle after
                if (scan_issue)
                begin
                    col_next  = col_reg + CW'(1);
                    pend_next = 1'b1;
                    pcol_next = col_reg[IW-1:0];
                end
                if (pend_reg)
                begin
                    if (cmd_reg == CMD_DFS)
                    begin
                        if (scan_hit && !visited_reg[pcol_reg] && (sp_reg < SPW'(SD)))
                        begin
                            stk_we                 = 1'b1;
                            sp_next                = sp_reg + SPW'(1);
                            visited_next[pcol_reg] = 1'b1;
                        end
                    end
                    else if (scan_hit)
                    begin
                        deg_next = deg_reg + CW'(1);
                    end
                end
                if (!scan_issue && !pend_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    if (cmd_reg == CMD_DFS)
                    begin
                        value_next = '0;
                        visit_next = lab_reg;
                        n_next     = n_reg + SPW'(1);
                        if ((sp_reg == '0) || (n_reg + SPW'(1) == SPW'(SD)))
                        begin
                            last_next  = 1'b1;
                            sp_next    = '0;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            last_next  = 1'b0;
                            state_next = S_POP;
                        end
                    end
                    else
                    begin
                        value_next = DATA_W'(deg_reg);
                        visit_next = '0;
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_addr] <= adj_wdata;
        end
        adj_q <= adj_mem[adj_addr];
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_q <= stk_mem[stk_raddr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        la_reg     <= la_next;
        lb_reg     <= lb_next;
        w_reg      <= w_next;
        ia_reg     <= ia_next;
        row_reg    <= row_next;
        top_reg    <= top_next;
        lab_reg    <= lab_next;
        col_reg    <= col_next;
        pcol_reg   <= pcol_next;
        deg_reg    <= deg_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        visit_reg  <= visit_next;
        found_reg  <= found_next;
        last_reg   <= last_next;
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            count_reg   <= '0;
            sp_reg      <= '0;
            n_reg       <= '0;
            visited_reg <= '0;
            clr_reg     <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
            null_reg    <= '0;
            limit_reg   <= LIMIT_W'(16);
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sp_reg      <= sp_next;
            n_reg       <= n_next;
            visited_reg <= visited_next;
            clr_reg     <= clr_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NULL_EDGE:    null_reg  <= cfg_data;
                    REG_VERTEX_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:          null_reg  <= null_reg;
                endcase
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign value       = value_reg;
    assign visit_label = visit_reg;
    assign found       = found_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_found_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && found |-> last)
        else $error("found beat without last");

    a_no_beat_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !done)
        else $error("result beat during memory sweep");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(SD))
        else $error("stack pointer beyond depth");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command != CMD_INSERT) && (command == CMD_SET ||
        command == CMD_DEGREE || command == CMD_WEIGHT) |=> busy)
        else $error("lookup command did not hold busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_VERTICES))
        else $error("vertex count beyond table size");
`endif

endmodule

`default_nettype wire

>>> rtl/amdfs_vtab.sv
`timescale 1ns / 1ps
`default_nettype none

module amdfs_vtab #(
    parameter int MAX_VERTICES = 16,
    localparam int IW = $clog2(MAX_VERTICES),
    localparam int CW = $clog2(MAX_VERTICES + 1)
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  amdfs_pkg::vt_req_t              req,
    input  wire [IW-1:0]                    idx,
    input  wire [amdfs_pkg::LABEL_W-1:0]    label,
    input  wire [CW-1:0]                    count,
    output amdfs_pkg::vt_rsp_t              rsp,
    output logic [IW-1:0]                   lk_idx,
    output logic [amdfs_pkg::LABEL_W-1:0]   rd_data
);
    import amdfs_pkg::*;

    logic [LABEL_W-1:0] mem [MAX_VERTICES];
    logic [LABEL_W-1:0] q_reg;
    logic [IW-1:0]      raddr;

    logic               busy_reg, busy_next;
    logic [IW-1:0]      ptr_reg, ptr_next;
    logic [LABEL_W-1:0] key_reg, key_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic               hit_reg, hit_next;
    logic [IW-1:0]      res_reg, res_next;

    // scan labels from index 0, one read per cycle, first match wins
    always_comb
    begin
        busy_next = busy_reg;
        ptr_next  = ptr_reg;
        key_next  = key_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        hit_next  = hit_reg;
        res_next  = res_reg;
        raddr     = req.rd ? idx : ptr_reg;
        if (req.lk_start)
        begin
            key_next = label;
            cnt_next = count;
            ptr_next = '0;
            raddr    = '0;
            if (count == '0)
            begin
                done_next = 1'b1;
                hit_next  = 1'b0;
                busy_next = 1'b0;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (q_reg == key_reg)
            begin
                done_next = 1'b1;
                hit_next  = 1'b1;
                res_next  = ptr_reg;
                busy_next = 1'b0;
            end
            else if (CW'(ptr_reg) + CW'(1) == cnt_reg)
            begin
                done_next = 1'b1;
                hit_next  = 1'b0;
                busy_next = 1'b0;
            end
            else
            begin
                ptr_next = ptr_reg + IW'(1);
                raddr    = ptr_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[idx] <= label;
        end
        q_reg <= mem[raddr];
        key_reg <= key_next;
        cnt_reg <= cnt_next;
        ptr_reg <= ptr_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            hit_reg  <= hit_next;
        end
    end

    assign rsp.lk_done = done_reg;
    assign rsp.lk_hit  = hit_reg;
    assign lk_idx      = res_reg;
    assign rd_data     = q_reg;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import amdfs_pkg::*;

    localparam int NV = 16;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   value;
        logic [LABEL_W-1:0]  visit_label;
        logic                found;
        logic                last;
    } graph_beat_t;

    // Scoreboard: graph shadow plus queue of predicted result beats.
    class graph_scoreboard;
        logic [DATA_W-1:0]  null_w;
        int                 limit;
        logic [LABEL_W-1:0] labels[NV];
        int                 count;
        logic [DATA_W-1:0]  adj[NV*NV];
        graph_beat_t        pending[$];
        int                 errors;

        function new();
            null_w = '0;
            limit  = 16;
            count  = 0;
            errors = 0;
            foreach (adj[i]) adj[i] = '0;
            foreach (labels[i]) labels[i] = '0;
        endfunction

        function bit find_label(logic [LABEL_W-1:0] lab, output int idx);
            idx = 0;
            for (int i = 0; i < count && i < NV; i++)
                if (labels[i] == lab) begin
                    idx = i;
                    return 1;
                end
            return 0;
        endfunction

        function void push_beat(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] v,
                                logic [LABEL_W-1:0] lab, logic f, logic l);
            graph_beat_t b;
            b.status = st; b.value = v; b.visit_label = lab; b.found = f; b.last = l;
            pending.push_back(b);
        endfunction

        function void predict_search(logic [LABEL_W-1:0] org, logic [LABEL_W-1:0] dst);
            int stk[$];
            bit seen[NV];
            int oi, top, row, n;
            logic [LABEL_W-1:0] lab;
            foreach (seen[i]) seen[i] = 0;
            n = 0;
            if (org == dst) begin
                push_beat(ST_OK, '0, org, 1, 1);
                return;
            end
            if (!find_label(org, oi)) begin
                push_beat(ST_MISS, '0, org, 0, 1);
                return;
            end
            stk.push_back(oi);
            while (stk.size() > 0 && n < NV + 1) begin
                top = stk.pop_back();
                lab = labels[top];
                if (lab == dst) begin
                    push_beat(ST_OK, '0, lab, 1, 1);
                    return;
                end
                if (!find_label(lab, row)) row = top;
                for (int i = 0; i < count && i < NV; i++)
                    if (adj[row*NV+i] != null_w && !seen[i] && stk.size() < NV + 1) begin
                        stk.push_back(i);
                        seen[i] = 1;
                    end
                n++;
                // the pop cap forces last on the final beat
                push_beat(ST_OK, '0, lab, 0, (stk.size() == 0 || n == NV + 1));
            end
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [LABEL_W-1:0] la,
                                   logic [LABEL_W-1:0] lb, logic [DATA_W-1:0] w);
            int ia, ib, deg;
            case (cmd)
                CMD_INSERT: begin
                    if (count >= (limit < NV ? limit : NV))
                        push_beat(ST_FULL, '0, '0, 0, 1);
                    else begin
                        labels[count] = la;
                        count++;
                        push_beat(ST_OK, '0, '0, 0, 1);
                    end
                end
                CMD_SET: begin
                    if (find_label(la, ia) && find_label(lb, ib)) begin
                        adj[ia*NV+ib] = w;
                        push_beat(ST_OK, '0, '0, 0, 1);
                    end else
                        push_beat(ST_MISS, '0, '0, 0, 1);
                end
                CMD_DEGREE: begin
                    if (!find_label(la, ia))
                        push_beat(ST_MISS, '0, '0, 0, 1);
                    else begin
                        deg = 0;
                        for (int i = 0; i < count; i++)
                            if (adj[ia*NV+i] != null_w) deg++;
                        push_beat(ST_OK, DATA_W'(deg), '0, 0, 1);
                    end
                end
                CMD_WEIGHT: begin
                    if (find_label(la, ia) && find_label(lb, ib))
                        push_beat(ST_OK, adj[ia*NV+ib], '0, 0, 1);
                    else
                        push_beat(ST_MISS, '0, '0, 0, 1);
                end
                CMD_DFS: predict_search(la, lb);
                default: push_beat(ST_OK, '0, '0, 0, 1);
            endcase
        endfunction

        function void check_beat(graph_beat_t got);
            graph_beat_t exp_b;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat got %h", $realtime, got);
                errors++;
                return;
            end
            exp_b = pending.pop_front();
            if (got.status !== exp_b.status)
                $display("%0t: status exp %0d got %0d", $realtime, exp_b.status, got.status);
            if (got.value !== exp_b.value)
                $display("%0t: value exp %0d got %0d", $realtime,
                         $signed(exp_b.value), $signed(got.value));
            if (got.visit_label !== exp_b.visit_label)
                $display("%0t: visit_label exp %0d got %0d", $realtime,
                         exp_b.visit_label, got.visit_label);
            if (got.found !== exp_b.found)
                $display("%0t: found exp %0d got %0d", $realtime, exp_b.found, got.found);
            if (got.last !== exp_b.last)
                $display("%0t: last exp %0d got %0d", $realtime, exp_b.last, got.last);
            if (got !== exp_b) errors++;
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     command = '0;
    logic [LABEL_W-1:0]   label_a = '0;
    logic [LABEL_W-1:0]   label_b = '0;
    logic [DATA_W-1:0]    weight = '0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [DATA_W-1:0]    value;
    logic [LABEL_W-1:0]   visit_label;
    logic                 found;
    logic                 last;

    graph_scoreboard sb = new();
    int idle_pct = 0;
    int quiet_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    adjacency_matrix_dfs_engine_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .label_a(label_a), .label_b(label_b), .weight(weight),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .status(status), .value(value), .visit_label(visit_label),
        .found(found), .last(last)
    );

    // Sample result beats at the rising edge; count quiet cycles for the watchdog.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_beat({status, value, visit_label, found, last});
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Drive one command beat: random idle gaps, then hold start until accepted.
    // Start stays high after the beat until the next idle gap or drain drops it.
    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [LABEL_W-1:0] la,
                            logic [LABEL_W-1:0] lb, logic [DATA_W-1:0] w);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        label_a <= la;
        label_b <= lb;
        weight  <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_command(cmd, la, lb, w);
        @(negedge clk);
    endtask

    // Wait for all predicted beats, then let the engine settle before a write.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_NULL_EDGE) sb.null_w = d;
        else sb.limit = d[LIMIT_W-1:0];
    endtask

    // Pick a label: mostly one already inserted, sometimes a random one.
    function automatic logic [LABEL_W-1:0] pick_label();
        if (sb.count > 0 && $urandom_range(9) < 8)
            return sb.labels[$urandom_range(sb.count - 1)];
        return LABEL_W'($urandom);
    endfunction

    // Weight: often the null value or a small set so edges exist and vanish.
    function automatic logic [DATA_W-1:0] pick_weight();
        case ($urandom_range(5))
            0: return sb.null_w;
            1: return DATA_W'($urandom);
            2: return 16'h8000;
            3: return 16'h7fff;
            default: return DATA_W'($urandom_range(1, 9));
        endcase
    endfunction

    task automatic random_phase(int n, int pct);
        int c;
        idle_pct = pct;
        for (int k = 0; k < n; k++) begin
            c = $urandom_range(99);
            if (c < 12)       send_cmd(CMD_INSERT, LABEL_W'($urandom), '0, DATA_W'($urandom));
            else if (c < 50)  send_cmd(CMD_SET, pick_label(), pick_label(), pick_weight());
            else if (c < 60)  send_cmd(CMD_DEGREE, pick_label(), pick_label(), '0);
            else if (c < 70)  send_cmd(CMD_WEIGHT, pick_label(), pick_label(), '0);
            else if (c < 97)  send_cmd(CMD_DFS, pick_label(), pick_label(), '0);
            else              send_cmd(CMD_W'($urandom_range(5, 7)), LABEL_W'($urandom),
                                       LABEL_W'($urandom), DATA_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, each command, misses, full table, self search.
        write_reg(REG_VERTEX_LIMIT, 16'd3);
        send_cmd(CMD_DFS, 8'd7, 8'd7, '0);
        send_cmd(CMD_DFS, 8'd1, 8'd2, '0);
        send_cmd(CMD_INSERT, 8'h00, 8'hff, 16'h8000);
        send_cmd(CMD_INSERT, 8'hff, 8'h00, 16'h7fff);
        send_cmd(CMD_INSERT, 8'h00, '0, '0);
        send_cmd(CMD_INSERT, 8'h55, '0, '0);
        send_cmd(CMD_SET, 8'h00, 8'hff, 16'h7fff);
        send_cmd(CMD_SET, 8'hff, 8'h00, 16'h8000);
        send_cmd(CMD_SET, 8'h00, 8'h00, 16'hffff);
        send_cmd(CMD_SET, 8'h12, 8'h00, 16'h1);
        send_cmd(CMD_DEGREE, 8'h00, '0, '0);
        send_cmd(CMD_DEGREE, 8'h99, '0, '0);
        send_cmd(CMD_WEIGHT, 8'hff, 8'h00, '0);
        send_cmd(CMD_WEIGHT, 8'h00, 8'h99, '0);
        send_cmd(CMD_DFS, 8'h00, 8'hff, '0);
        send_cmd(CMD_DFS, 8'hff, 8'h77, '0);
        send_cmd(3'd5, 8'hff, 8'hff, 16'hffff);
        send_cmd(3'd7, '0, '0, '0);
        write_reg(REG_NULL_EDGE, 16'h7fff);
        send_cmd(CMD_DEGREE, 8'hff, '0, '0);
        send_cmd(CMD_DFS, 8'h00, 8'h42, '0);
        write_reg(REG_NULL_EDGE, 16'h8000);
        send_cmd(CMD_DEGREE, 8'h00, '0, '0);
        write_reg(REG_VERTEX_LIMIT, 16'd0);
        send_cmd(CMD_INSERT, 8'h33, '0, '0);

        // Random phases with varied null value, limit and sender idling.
        write_reg(REG_NULL_EDGE, 16'h0000);
        write_reg(REG_VERTEX_LIMIT, 16'd16);
        random_phase(90, 0);
        write_reg(REG_NULL_EDGE, 16'd5);
        random_phase(80, 72);
        write_reg(REG_VERTEX_LIMIT, 16'd31);
        random_phase(80, 19);
        write_reg(REG_NULL_EDGE, 16'h8000);
        random_phase(70, 0);

        drain();
        repeat (400) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> sim.f
rtl/amdfs_pkg.sv
rtl/amdfs_vtab.sv
rtl/adjacency_matrix_dfs_engine_top.sv
tb/tb.sv
